// ===== hdl/mlr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mlr_pkg;

  // Default coordinate width in bits
  localparam int unsigned COORD_BITS_DEF = 12;

  // Opcodes carried on the input tuser bit
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Octant of the active line: major axis and step directions
  typedef struct packed {
    logic major_is_y;
    logic neg_x_step;
    logic neg_y_step;
  } octant_t;

endpackage : mlr_pkg

`default_nettype wire

// ===== hdl/mlr_octant.sv =====
// Line setup: octant classification and midpoint increments from two endpoints.
// Depends on mlr_pkg (octant_t).
`default_nettype none

module mlr_octant #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  output mlr_pkg::octant_t             octant_o,
  output logic [COORD_BITS-1:0]        major_len_o,
  output logic [COORD_BITS+1:0]        inc_straight_o,
  output logic signed [COORD_BITS+2:0] inc_diagonal_o,
  output logic signed [COORD_BITS+2:0] decision_o
);
  import mlr_pkg::*;

  logic                  neg_x, neg_y, major_y;
  logic [COORD_BITS-1:0] dx, dy, maj, mnr;

  // Step signs and absolute deltas
  assign neg_x = end_x_i < start_x_i;
  assign neg_y = end_y_i < start_y_i;
  assign dx    = neg_x ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
  assign dy    = neg_y ? (start_y_i - end_y_i) : (end_y_i - start_y_i);

  // Ties go to y-major
  assign major_y = dy >= dx;
  assign maj     = major_y ? dy : dx;
  assign mnr     = major_y ? dx : dy;

  assign octant_o.major_is_y = major_y;
  assign octant_o.neg_x_step = neg_x;
  assign octant_o.neg_y_step = neg_y;
  assign major_len_o         = maj;

  // 2*minor, 2*minor - 2*major, 2*minor - major
  assign inc_straight_o = {1'b0, mnr, 1'b0};
  assign inc_diagonal_o = $signed({2'b00, mnr, 1'b0}) - $signed({2'b00, maj, 1'b0});
  assign decision_o     = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});

endmodule : mlr_octant

`default_nettype wire

// ===== hdl/mlr_stepper.sv =====
// One midpoint step: next pixel, decision and remaining count of the active line.
// Depends on mlr_pkg (octant_t).
`default_nettype none

module mlr_stepper #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        cur_x_i,
  input  logic [COORD_BITS-1:0]        cur_y_i,
  input  logic [COORD_BITS-1:0]        steps_left_i,
  input  logic signed [COORD_BITS+2:0] decision_i,
  input  logic [COORD_BITS+1:0]        inc_straight_i,
  input  logic signed [COORD_BITS+2:0] inc_diagonal_i,
  input  mlr_pkg::octant_t             octant_i,
  output logic [COORD_BITS-1:0]        next_x_o,
  output logic [COORD_BITS-1:0]        next_y_o,
  output logic [COORD_BITS-1:0]        next_steps_o,
  output logic signed [COORD_BITS+2:0] next_decision_o,
  output logic                         done_o
);
  import mlr_pkg::*;

  logic                  diag, step_x, step_y;
  logic [COORD_BITS-1:0] mov_x, mov_y;

  // Non-negative decision (midpoint tie included) takes the diagonal step
  assign diag   = ~decision_i[COORD_BITS+2];
  assign step_x = ~octant_i.major_is_y | diag;
  assign step_y =  octant_i.major_is_y | diag;

  assign mov_x = octant_i.neg_x_step ? (cur_x_i - 1'b1) : (cur_x_i + 1'b1);
  assign mov_y = octant_i.neg_y_step ? (cur_y_i - 1'b1) : (cur_y_i + 1'b1);

  assign next_x_o = step_x ? mov_x : cur_x_i;
  assign next_y_o = step_y ? mov_y : cur_y_i;

  // Decision update
  assign next_decision_o = decision_i +
                           (diag ? inc_diagonal_i : $signed({1'b0, inc_straight_i}));

  // Pixel count
  assign next_steps_o = steps_left_i - 1'b1;
  assign done_o       = next_steps_o == '0;

endmodule : mlr_stepper

`default_nettype wire

// ===== hdl/midpoint_line_raster.sv =====
// Top level of the midpoint line rasterizer: input register, line state, result register.
// Depends on mlr_pkg, mlr_octant and mlr_stepper.
//
//  channel  | dir | tdata (low bit up)                  | tuser        | tlast
//  s_axis   | in  | start_x, start_y, end_x, end_y      | opcode       | -
//  m_axis   | out | pixel_x, pixel_y                    | pixel_valid  | last_pixel
//
// One word per clock sustained while m_axis_tready stays high; an accepted input word
// passes through the input register, then the result register, before its result leaves.
// The sustained rate is set by the decision add/compare loop on the line state.
// A stalled result holds the next word in the input register; with both registers full
// s_axis_tready drops until the result word is taken.
// Reset leaves the block idle: a step word before any start returns pixel_valid = 0.
`default_nettype none

module midpoint_line_raster #(
  parameter int unsigned COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // opcode
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // pixel_valid
  output logic                                   m_axis_tuser,
  // last_pixel
  output logic                                   m_axis_tlast
);
  import mlr_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned OUT_W = ((2*COORD_BITS+7)/8)*8;

  // Input register
  logic          in_vld_q;
  logic          in_op_q;
  logic [CB-1:0] in_sx_q, in_sy_q, in_ex_q, in_ey_q;

  // Line state
  logic                 active_q;
  octant_t              oct_q;
  logic [CB-1:0]        cur_x_q, cur_y_q, steps_q;
  logic signed [CB+2:0] dec_q, inc_diag_q;
  logic [CB+1:0]        inc_str_q;

  // Result register
  logic          out_vld_q;
  logic [CB-1:0] out_x_q, out_y_q;
  logic          out_pv_q, out_last_q;

  logic adv;

  // Setup and step results
  octant_t              su_oct;
  logic [CB-1:0]        su_maj;
  logic [CB+1:0]        su_inc_str;
  logic signed [CB+2:0] su_inc_diag, su_dec;
  logic [CB-1:0]        st_x, st_y, st_steps;
  logic signed [CB+2:0] st_dec;
  logic                 st_done;

  // Word moves from input register to result register
  assign adv           = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;

  mlr_octant #(.COORD_BITS(CB)) u_octant (
    .start_x_i      (in_sx_q),
    .start_y_i      (in_sy_q),
    .end_x_i        (in_ex_q),
    .end_y_i        (in_ey_q),
    .octant_o       (su_oct),
    .major_len_o    (su_maj),
    .inc_straight_o (su_inc_str),
    .inc_diagonal_o (su_inc_diag),
    .decision_o     (su_dec)
  );

  mlr_stepper #(.COORD_BITS(CB)) u_stepper (
    .cur_x_i         (cur_x_q),
    .cur_y_i         (cur_y_q),
    .steps_left_i    (steps_q),
    .decision_i      (dec_q),
    .inc_straight_i  (inc_str_q),
    .inc_diagonal_i  (inc_diag_q),
    .octant_i        (oct_q),
    .next_x_o        (st_x),
    .next_y_o        (st_y),
    .next_steps_o    (st_steps),
    .next_decision_o (st_dec),
    .done_o          (st_done)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q <= s_axis_tuser;
      in_sx_q <= s_axis_tdata[CB-1:0];
      in_sy_q <= s_axis_tdata[2*CB-1:CB];
      in_ex_q <= s_axis_tdata[3*CB-1:2*CB];
      in_ey_q <= s_axis_tdata[4*CB-1:3*CB];
    end
  end

  // Line state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      oct_q      <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      steps_q    <= '0;
      dec_q      <= '0;
      inc_str_q  <= '0;
      inc_diag_q <= '0;
    end else if (adv) begin
      if (in_op_q == OP_START) begin
        active_q   <= su_maj != '0;
        oct_q      <= su_oct;
        cur_x_q    <= in_sx_q;
        cur_y_q    <= in_sy_q;
        steps_q    <= su_maj;
        dec_q      <= su_dec;
        inc_str_q  <= su_inc_str;
        inc_diag_q <= su_inc_diag;
      end else if (active_q) begin
        active_q <= ~st_done;
        cur_x_q  <= st_x;
        cur_y_q  <= st_y;
        steps_q  <= st_steps;
        dec_q    <= st_dec;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_op_q == OP_START) begin
        out_x_q    <= in_sx_q;
        out_y_q    <= in_sy_q;
        out_pv_q   <= 1'b1;
        out_last_q <= su_maj == '0;
      end else if (active_q) begin
        out_x_q    <= st_x;
        out_y_q    <= st_y;
        out_pv_q   <= 1'b1;
        out_last_q <= st_done;
      end else begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_pv_q   <= 1'b0;
        out_last_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_pv_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // An idle-step word carries no pixel and no end flag
  a_idle_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("idle result word carries nonzero fields");

  // An active line always has pixels left
  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> steps_q != '0)
    else $error("line active with zero steps left");

  // A single-point line leaves the block idle
  a_point_line_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_op_q == OP_START && su_maj == '0 |=> !active_q && m_axis_tlast)
    else $error("single-point line not closed");

  // The last step of a line ends it and flags the end point
  a_last_step_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_op_q == OP_STEP && active_q && steps_q == CB'(1)
    |=> !active_q && m_axis_tlast && m_axis_tuser)
    else $error("final step did not close the line");

  // A step while idle yields an invalid pixel and leaves the state idle
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_op_q == OP_STEP && !active_q |=> !m_axis_tuser && !active_q)
    else $error("step while idle produced a pixel");
`endif

endmodule : midpoint_line_raster

`default_nettype wire

// ===== tb/mlr_pixel_checker.sv =====
// Pixel checker for the midpoint line rasterizer: watches both stream channels,
// predicts every result word from the accepted input words and compares in order.
// Depends on mlr_pkg (opcodes, octant type).
`timescale 1ns / 1ps

module mlr_pixel_checker #(
  parameter int unsigned CB = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up
  input  logic [((4*CB+7)/8)*8-1:0]        s_axis_tdata,
  // opcode
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_x, pixel_y from bit 0 up
  input  logic [((2*CB+7)/8)*8-1:0]        m_axis_tdata,
  // pixel_valid
  input  logic                             m_axis_tuser,
  // last_pixel
  input  logic                             m_axis_tlast,
  output int                               fail_cnt_o,
  output int                               pending_o,
  output int                               checked_o
);
  import mlr_pkg::*;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          valid;
    logic          last;
  } pixel_t;

  // Expected pixels, oldest first
  pixel_t pixel_exp_q[$];

  // Tracked line state
  logic [CB-1:0]  cur_x, cur_y, steps_left;
  logic signed [CB+2:0] decision;
  logic [CB+1:0]  inc_straight;
  logic signed [CB+2:0] inc_diagonal;
  octant_t        oct;
  logic           line_active;

  function automatic logic [CB-1:0] nudge(logic [CB-1:0] v, logic neg);
    return neg ? v - 1'b1 : v + 1'b1;
  endfunction

  // Advance the tracked line by one input word and queue the pixel it yields
  task automatic trace_word(input logic op, input logic [4*CB-1:0] data);
    logic [CB-1:0] sx, sy, ex, ey, dx, dy, maj, mnr;
    logic          diag;
    pixel_t        px;
    sx = data[CB-1:0];
    sy = data[2*CB-1:CB];
    ex = data[3*CB-1:2*CB];
    ey = data[4*CB-1:3*CB];
    if (op == OP_START) begin
      oct.neg_x_step = ex < sx;
      oct.neg_y_step = ey < sy;
      dx = oct.neg_x_step ? sx - ex : ex - sx;
      dy = oct.neg_y_step ? sy - ey : ey - sy;
      // tie goes to y-major
      oct.major_is_y = dy >= dx;
      maj = oct.major_is_y ? dy : dx;
      mnr = oct.major_is_y ? dx : dy;
      inc_straight = (CB+2)'(2 * int'(mnr));
      inc_diagonal = (CB+3)'(2 * int'(mnr) - 2 * int'(maj));
      decision     = (CB+3)'(2 * int'(mnr) - int'(maj));
      cur_x = sx;
      cur_y = sy;
      steps_left = maj;
      line_active = maj != 0;
      px = '{x: sx, y: sy, valid: 1'b1, last: maj == 0};
    end else if (!line_active) begin
      px = '{x: '0, y: '0, valid: 1'b0, last: 1'b0};
    end else begin
      // midpoint tie takes the diagonal step
      diag = decision >= 0;
      if (oct.major_is_y) begin
        cur_y = nudge(cur_y, oct.neg_y_step);
        if (diag) cur_x = nudge(cur_x, oct.neg_x_step);
      end else begin
        cur_x = nudge(cur_x, oct.neg_x_step);
        if (diag) cur_y = nudge(cur_y, oct.neg_y_step);
      end
      decision = (CB+3)'(int'(decision) +
                         (diag ? int'(inc_diagonal) : int'(inc_straight)));
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) line_active = 1'b0;
      px = '{x: cur_x, y: cur_y, valid: 1'b1, last: steps_left == 0};
    end
    pixel_exp_q.push_back(px);
  endtask

  // Watch both channels; inputs are traced before results are popped
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      pixel_exp_q.delete();
      cur_x <= '0;
      cur_y <= '0;
      steps_left <= '0;
      decision <= '0;
      inc_straight <= '0;
      inc_diagonal <= '0;
      oct <= '0;
      line_active <= 1'b0;
      fail_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        trace_word(s_axis_tuser, s_axis_tdata[4*CB-1:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{x: m_axis_tdata[CB-1:0], y: m_axis_tdata[2*CB-1:CB],
                valid: m_axis_tuser, last: m_axis_tlast};
        if (pixel_exp_q.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d valid=%0b last=%0b",
                   $time, got.x, got.y, got.valid, got.last);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = pixel_exp_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected x=%0d y=%0d valid=%0b last=%0b,",
                     $time, want.x, want.y, want.valid, want.last,
                     " got x=%0d y=%0d valid=%0b last=%0b",
                     got.x, got.y, got.valid, got.last);
            fail_cnt_o <= fail_cnt_o + 1;
          end
          checked_o <= checked_o + 1;
        end
      end
      pending_o <= pixel_exp_q.size();
    end
  end

endmodule : mlr_pixel_checker

// ===== tb/tb.sv =====
// Testbench top for midpoint_line_raster: clock, reset, stimulus and verdict.
// Depends on mlr_pkg, midpoint_line_raster and mlr_pixel_checker.
`timescale 1ns / 1ps

module tb;
  import mlr_pkg::*;

  localparam int CB      = COORD_BITS_DEF;
  localparam int CMAX    = (1 << CB) - 1;
  localparam int TARGET  = 1250;
  localparam int LIMIT   = 400000;
  localparam int HOLD    = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [4*CB-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_START;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*CB-1:0]       m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int fail_cnt, pending, checked;
  int starts_sent = 0;
  int steps_sent = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  midpoint_line_raster #(.COORD_BITS(CB)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mlr_pixel_checker #(.CB(CB)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Result side: random back-pressure, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (sink_quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= $urandom_range(99) >= 17;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("%0t: run timed out with %0d pixels outstanding", $time, pending);
      $display("midpoint_line_raster: mismatch");
      $finish;
    end
  end

  function automatic logic [4*CB-1:0] rand_word();
    return (4*CB)'({$urandom, $urandom});
  endfunction

  // Full-range coordinate, biased toward the screen edges
  function automatic int pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(3);
    if (r < 20) return CMAX - $urandom_range(3);
    return $urandom_range(CMAX);
  endfunction

  // Coordinate within span of base, clamped to the screen
  function automatic int near(int base, int span);
    int v;
    v = base + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  function automatic int major_len(int sx, int sy, int ex, int ey);
    int dx, dy;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    return (dx > dy) ? dx : dy;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input logic op, input logic [4*CB-1:0] data);
    while (!src_quiet && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_START) starts_sent++;
    else steps_sent++;
  endtask

  // Start a line, then issue step words with junk payload
  task automatic draw_line(input int sx, sy, ex, ey, n_steps);
    send_word(OP_START, {CB'(ey), CB'(ex), CB'(sy), CB'(sx)});
    repeat (n_steps) send_word(OP_STEP, rand_word());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random sequence: mostly whole short lines, some cut short or overrun
  task automatic random_line();
    int r, sx, sy, ex, ey, maj, n;
    r = $urandom_range(99);
    if (r < 8) begin
      send_word(1'($urandom_range(1)), rand_word());
    end else if (r < 10) begin
      // full-range endpoints, abandoned early
      draw_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                $urandom_range(40));
    end else begin
      sx = pick_coord();
      sy = pick_coord();
      if (r < 15) begin
        ex = near(sx, 300);
        ey = near(sy, 300);
      end else begin
        ex = near(sx, 12);
        ey = near(sy, 12);
      end
      maj = major_len(sx, sy, ex, ey);
      if ($urandom_range(99) < 75) n = maj + $urandom_range(2);
      else n = $urandom_range(maj);
      draw_line(sx, sy, ex, ey, n);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: step while idle, single point, midpoint tie, vertical,
    // horizontal, restart while a line is active, step past the end
    send_word(OP_STEP, '1);
    draw_line(CMAX, CMAX, CMAX, CMAX, 1);
    draw_line(CMAX, 0, CMAX - 2, 1, 3);
    draw_line(0, CMAX, 0, CMAX - 3, 3);
    draw_line(100, 200, 103, 200, 3);
    draw_line(0, 0, CMAX, CMAX, 2);
    draw_line(10, 10, 7, 13, 3);
    drain();

    // Random lines with idling on both sides
    while (starts_sent + steps_sent < 450) random_line();

    // Long result hold-off while words keep coming, then wait for all results
    src_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (12) random_line();
    src_quiet = 1'b0;
    drain();

    // Stretch with no idling at all
    src_quiet = 1'b1;
    sink_quiet = 1'b1;
    while (starts_sent + steps_sent < 700) random_line();
    src_quiet = 1'b0;
    sink_quiet = 1'b0;

    while (starts_sent + steps_sent < TARGET) random_line();

    drain();
    repeat (8) @(posedge clk_i);
    $display("Drew %0d lines with %0d step words in all octants; %0d results checked.",
             starts_sent, steps_sent, checked);
    if (fail_cnt == 0 && pending == 0) $display("midpoint_line_raster: match");
    else $display("midpoint_line_raster: mismatch");
    $finish;
  end

endmodule : tb
